/* rtl/sbpa_pkg.sv */
// Shared types, table constants and a helper function for the segregated block pool allocator.
// Depends on nothing; every other file of the block but sbpa_ram imports it.
`default_nettype none

package sbpa_pkg;

    localparam int DEF_POOL_TOTAL   = 9;
    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int DEF_ADDRESS_BITS = 48;

    localparam int TABLE_POOLS  = 9;
    localparam int POOL_W       = 4;
    localparam int SLOT_TOTAL   = 600;
    localparam int SLOT_W       = 10;
    localparam int LINK_W       = 9;
    localparam int COUNT_W      = 9;
    localparam int INDEX_W      = 8;
    localparam int BYTES_W      = 13;
    localparam int SIZE_W       = 16;
    localparam int DIFF_W       = 17;
    localparam int SPAN_W       = 18;
    localparam int OFFSET_W     = 32;
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_W      = 17;
    localparam int ODD_W        = 6;
    localparam int SHIFT_W      = 4;
    localparam int OUT_ADDR_W   = 48;
    localparam int STATUS_W     = 3;
    localparam int POOL_WORD_W  = LINK_W + COUNT_W;
    localparam int BLOCK_WORD_W = 1 + LINK_W;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 64;

    localparam logic [LINK_W-1:0] LINK_NULL = '1;

    typedef logic [BYTES_W-1:0]  t_bytes_tab  [TABLE_POOLS];
    typedef logic [COUNT_W-1:0]  t_count_tab  [TABLE_POOLS];
    typedef logic [SLOT_W-1:0]   t_slot_tab   [TABLE_POOLS];
    typedef logic [SPAN_W-1:0]   t_span_tab   [TABLE_POOLS];
    typedef logic [SHIFT_W-1:0]  t_shift_tab  [TABLE_POOLS];
    typedef logic [ODD_W-1:0]    t_odd_tab    [TABLE_POOLS];
    typedef logic [RECIP_W-1:0]  t_recip_tab  [TABLE_POOLS];
    typedef logic [OFFSET_W-1:0] t_offset_tab [TABLE_POOLS];

    localparam t_bytes_tab BLK_BYTES = '{
        13'd16, 13'd32, 13'd64, 13'd128, 13'd256, 13'd512, 13'd1024, 13'd2048, 13'd4480};
    localparam t_count_tab BLK_COUNT = '{
        9'd256, 9'd128, 9'd64, 9'd32, 9'd16, 9'd8, 9'd16, 9'd64, 9'd16};
    localparam t_slot_tab SLOT_BASE = '{
        10'd0, 10'd256, 10'd384, 10'd448, 10'd480, 10'd496, 10'd504, 10'd520, 10'd584};
    localparam t_span_tab BLK_SPAN = '{
        18'd4096, 18'd4096, 18'd4096, 18'd4096, 18'd4096, 18'd4096,
        18'd16384, 18'd131072, 18'd71680};
    // block size = odd factor << shift; divide by the odd part through a reciprocal
    localparam t_shift_tab BLK_SHIFT = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd7};
    localparam t_odd_tab BLK_ODD = '{
        6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd35};
    localparam t_recip_tab BLK_RECIP = '{
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd1873};

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_TOO_LARGE   = 3'd1,
        STAT_NO_MEMORY   = 3'd2,
        STAT_INVALID     = 3'd3,
        STAT_MISALIGNED  = 3'd4,
        STAT_DOUBLE_FREE = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOCATE,
        S_DIVIDE,
        S_CHECK,
        S_HEAD,
        S_LINK,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [POOL_W-1:0]   pool;
        logic [DIFF_W-1:0]   diff;
    } t_locate;

    typedef struct packed {
        logic [INDEX_W-1:0]  quot;
        logic [DIFF_W-1:0]   scaled;
        logic                low_nz;
    } t_index;

    // Start offset of each pool: earlier pools rounded up to whole pages.
    function automatic t_offset_tab pool_offsets(input int page);
        t_offset_tab          res;
        logic [OFFSET_W-1:0]  acc;
        logic [OFFSET_W-1:0]  rounded;
        acc = '0;
        for (int p = 0; p < TABLE_POOLS; p++) begin
            res[p]  = acc;
            rounded = '0;
            for (int n = 0; n < 1024; n++) begin
                if (rounded < OFFSET_W'(BLK_SPAN[p])) begin
                    rounded = rounded + OFFSET_W'(page);
                end
            end
            acc = acc + rounded;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/sbpa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the pool head table and the per-block link and free-flag store.
`default_nettype none

module sbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sbpa_locate.sv */
// Pool selection: size match for allocations, one address lane per pool for frees.
// Depends on sbpa_pkg for the pool tables and the page-rounded offsets.
`default_nettype none

module sbpa_locate
    import sbpa_pkg::*;
#(
    parameter int ADDR_W     = DEF_ADDRESS_BITS,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int LIVE_POOLS = DEF_POOL_TOTAL
) (
    input  wire t_op                 i_op,
    input  wire logic [SIZE_W-1:0]   i_size,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic [ADDR_W-1:0]   i_base,
    output t_locate                  o_loc,
    output logic      [ADDR_W-1:0]   o_start
);

    localparam t_offset_tab POOL_OFF = pool_offsets(PAGE_BYTES);

    logic [ADDR_W-1:0]      w_start [TABLE_POOLS];
    logic [ADDR_W-1:0]      w_diff  [TABLE_POOLS];
    logic [TABLE_POOLS-1:0] w_hit;
    logic [TABLE_POOLS-1:0] w_fits;

    for (genvar p = 0; p < TABLE_POOLS; p++) begin : g_lane
        assign w_start[p] = i_base + ADDR_W'(POOL_OFF[p]);
        assign w_diff[p]  = i_addr - w_start[p];
        assign w_hit[p]   = (p < LIVE_POOLS) && (w_diff[p] < ADDR_W'(BLK_SPAN[p]));
        assign w_fits[p]  = (p < LIVE_POOLS) && (SIZE_W'(BLK_BYTES[p]) >= i_size);
    end

    // lowest matching pool wins: scan from the top so the lowest is written last
    always_comb begin
        o_loc.status = STAT_OK;
        o_loc.pool   = '0;
        o_loc.diff   = '0;
        o_start      = w_start[0];
        if (i_op == OP_ALLOC) begin
            if (w_fits == '0) begin
                o_loc.status = STAT_TOO_LARGE;
            end else begin
                for (int p = TABLE_POOLS - 1; p >= 0; p--) begin
                    if (w_fits[p]) begin
                        o_loc.pool = POOL_W'(p);
                        o_start    = w_start[p];
                    end
                end
            end
        end else begin
            if (i_addr == '0 || w_hit == '0) begin
                o_loc.status = STAT_INVALID;
            end else begin
                for (int p = TABLE_POOLS - 1; p >= 0; p--) begin
                    if (w_hit[p]) begin
                        o_loc.pool = POOL_W'(p);
                        o_loc.diff = DIFF_W'(w_diff[p]);
                        o_start    = w_start[p];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sbpa_index.sv */
// Block number from the byte offset within a pool: shift, then reciprocal multiply.
// Depends on sbpa_pkg for the shift and reciprocal tables.
`default_nettype none

module sbpa_index
    import sbpa_pkg::*;
(
    input  wire logic [POOL_W-1:0] i_pool,
    input  wire logic [DIFF_W-1:0] i_diff,
    output t_index                 o_index
);

    localparam int PROD_W = DIFF_W + RECIP_W;

    logic [SHIFT_W-1:0] w_shift;
    logic [DIFF_W-1:0]  w_scaled;
    logic [DIFF_W-1:0]  w_low;
    logic [PROD_W-1:0]  w_prod;

    assign w_shift  = BLK_SHIFT[i_pool];
    assign w_scaled = i_diff >> w_shift;
    assign w_low    = i_diff & ((DIFF_W'(1) << w_shift) - DIFF_W'(1));
    assign w_prod   = PROD_W'(w_scaled) * PROD_W'(BLK_RECIP[i_pool]);

    assign o_index.quot   = INDEX_W'(w_prod >> RECIP_SHIFT);
    assign o_index.scaled = w_scaled;
    assign o_index.low_nz = |w_low;

endmodule

`default_nettype wire

/* rtl/segregated_block_pool_allocator.sv */
// Segregated block pool allocator: up to nine fixed-size pools with LIFO free lists.
//
// Channels: s_axis carries requests (tuser selects allocate or free), m_axis
// carries one result per request; a transfer happens when tvalid and tready are
// both high. The arena base is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must write it only while the block is idle, as the block does not enforce it.
// Steps: an allocation goes through S_LOCATE, S_HEAD, S_LINK, S_UPDATE, S_DONE; a free
// through S_LOCATE, S_DIVIDE, S_CHECK, S_LINK, S_UPDATE, S_DONE. An empty pool leaves
// after S_LINK, a misaligned free after S_CHECK, and rejected requests (too large,
// null or stray address) go from S_LOCATE straight to S_DONE. A new request is taken
// only in S_IDLE, once the last result is loaded; each does a read-modify-write of
// the pool head table, then the block link store, both synchronous registered-read RAMs.
// Reset: a clearing pass over all 600 block slots rebuilds every free list and sets
// every free flag; s_axis_tready stays low until it ends.
// Stall: the result sits in an output register; the next request is taken and
// worked on while it waits, and finishes once the register has been drained.
`default_nettype none

module segregated_block_pool_allocator
    import sbpa_pkg::*;
#(
    parameter int POOL_TOTAL   = DEF_POOL_TOTAL,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic                  s_axis_tuser,   // operation
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_size[15:0], address[63:16]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[2:0], block_address[50:3], pool_index[54:51], block_index[62:55], zero[63]
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [OUT_ADDR_W-1:0] i_cfg_wr_data
);

    localparam int ADDR_W     = ADDRESS_BITS;
    localparam int LIVE_POOLS = (POOL_TOTAL < TABLE_POOLS) ? POOL_TOTAL : TABLE_POOLS;

    t_state                   r_state;
    t_state                   n_state;
    logic [OUT_ADDR_W-1:0]    r_base;
    t_op                      r_op;
    logic [SIZE_W-1:0]        r_size;
    logic [ADDR_W-1:0]        r_addr;
    logic [POOL_W-1:0]        r_pool;
    logic [DIFF_W-1:0]        r_diff;
    logic [ADDR_W-1:0]        r_start;
    logic [DIFF_W-1:0]        r_scaled;
    logic                     r_low_nz;
    logic [INDEX_W-1:0]       r_idx;
    logic [LINK_W-1:0]        r_head;
    logic [COUNT_W-1:0]       r_total;
    logic [SLOT_W-1:0]        r_slot;
    logic [SPAN_W-1:0]        r_boff;
    t_status                  r_res_status;
    logic [OUT_ADDR_W-1:0]    r_res_addr;
    logic [POOL_W-1:0]        r_res_pool;
    logic [INDEX_W-1:0]       r_res_idx;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic [SLOT_W-1:0]        r_init_slot;
    logic [POOL_W-1:0]        r_init_pool;
    logic [COUNT_W-1:0]       r_init_j;

    t_locate                  w_loc;
    logic [ADDR_W-1:0]        w_start;
    t_index                   w_idx;
    logic                     w_accept;
    logic                     w_out_load;
    logic [DIFF_W-1:0]        w_rem;
    logic                     w_misaligned;
    logic [LINK_W-1:0]        w_pool_head;
    logic [COUNT_W-1:0]       w_pool_total;
    logic                     w_alloc_empty;
    logic [INDEX_W-1:0]       w_link_pick;
    logic [SLOT_W-1:0]        w_link_slot;
    logic [SPAN_W-1:0]        w_boff;
    logic [ADDR_W-1:0]        w_alloc_addr;
    logic                     w_blk_free;
    logic [LINK_W-1:0]        w_blk_link;
    logic [COUNT_W-1:0]       w_init_next;
    logic [LINK_W-1:0]        w_init_link;
    logic [POOL_W-1:0]        w_init_pool_idx;

    logic                     pool_wr_en;
    logic [POOL_W-1:0]        pool_wr_addr;
    logic [POOL_WORD_W-1:0]   pool_wr_data;
    logic                     pool_rd_en;
    logic [POOL_WORD_W-1:0]   pool_rd_data;
    logic                     blk_wr_en;
    logic [SLOT_W-1:0]        blk_wr_addr;
    logic [BLOCK_WORD_W-1:0]  blk_wr_data;
    logic                     blk_rd_en;
    logic [BLOCK_WORD_W-1:0]  blk_rd_data;

    sbpa_locate #(
        .ADDR_W     (ADDR_W),
        .PAGE_BYTES (PAGE_BYTES),
        .LIVE_POOLS (LIVE_POOLS)
    ) u_locate (
        .i_op    (r_op),
        .i_size  (r_size),
        .i_addr  (r_addr),
        .i_base  (ADDR_W'(r_base)),
        .o_loc   (w_loc),
        .o_start (w_start)
    );

    sbpa_index u_index (
        .i_pool  (r_pool),
        .i_diff  (r_diff),
        .o_index (w_idx)
    );

    sbpa_ram #(
        .WIDTH (POOL_WORD_W),
        .DEPTH (TABLE_POOLS)
    ) u_pool_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pool_wr_en),
        .i_wr_addr (pool_wr_addr),
        .i_wr_data (pool_wr_data),
        .i_rd_en   (pool_rd_en),
        .i_rd_addr (r_pool),
        .o_rd_data (pool_rd_data)
    );

    sbpa_ram #(
        .WIDTH (BLOCK_WORD_W),
        .DEPTH (SLOT_TOTAL)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_wr_en   (blk_wr_en),
        .i_wr_addr (blk_wr_addr),
        .i_wr_data (blk_wr_data),
        .i_rd_en   (blk_rd_en),
        .i_rd_addr (w_link_slot),
        .o_rd_data (blk_rd_data)
    );

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // remainder of the odd-factor division; any low bits or remainder means misaligned
    assign w_rem        = r_scaled - DIFF_W'(r_idx) * DIFF_W'(BLK_ODD[r_pool]);
    assign w_misaligned = r_low_nz || (w_rem != '0);

    assign w_pool_head   = pool_rd_data[POOL_WORD_W-1:COUNT_W];
    assign w_pool_total  = pool_rd_data[COUNT_W-1:0];
    assign w_alloc_empty = (w_pool_total == '0) || (w_pool_head >= BLK_COUNT[r_pool]);
    assign w_link_pick   = (r_op == OP_ALLOC) ? w_pool_head[INDEX_W-1:0] : r_idx;
    assign w_link_slot   = SLOT_BASE[r_pool] + SLOT_W'(w_link_pick);
    assign w_boff        = SPAN_W'(w_pool_head) * SPAN_W'(BLK_BYTES[r_pool]);
    assign w_alloc_addr  = r_start + ADDR_W'(r_boff);

    assign w_blk_free = blk_rd_data[LINK_W];
    assign w_blk_link = blk_rd_data[LINK_W-1:0];

    assign w_init_next     = r_init_j + COUNT_W'(1);
    assign w_init_link     = (w_init_next < BLK_COUNT[r_init_pool]) ? LINK_W'(w_init_next)
                                                                     : LINK_NULL;
    assign w_init_pool_idx = (r_init_slot < SLOT_W'(TABLE_POOLS)) ? POOL_W'(r_init_slot)
                                                                   : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init_slot == SLOT_W'(SLOT_TOTAL - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: begin
                if (w_loc.status != STAT_OK) begin
                    n_state = S_DONE;
                end else if (r_op == OP_ALLOC) begin
                    n_state = S_HEAD;
                end else begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: n_state = S_CHECK;
            S_CHECK: begin
                n_state = w_misaligned ? S_DONE : S_LINK;
            end
            S_HEAD:   n_state = S_LINK;
            S_LINK: begin
                n_state = (r_op == OP_ALLOC && w_alloc_empty) ? S_DONE : S_UPDATE;
            end
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_INIT;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        s_axis_tready = 1'b0;
        pool_rd_en    = 1'b0;
        blk_rd_en     = 1'b0;
        pool_wr_en    = 1'b0;
        pool_wr_addr  = r_pool;
        pool_wr_data  = '0;
        blk_wr_en     = 1'b0;
        blk_wr_addr   = r_slot;
        blk_wr_data   = '0;
        unique case (r_state)
            S_INIT: begin
                blk_wr_en    = 1'b1;
                blk_wr_addr  = r_init_slot;
                blk_wr_data  = {1'b1, w_init_link};
                pool_wr_en   = (r_init_slot < SLOT_W'(TABLE_POOLS));
                pool_wr_addr = w_init_pool_idx;
                pool_wr_data = {LINK_W'(0), BLK_COUNT[w_init_pool_idx]};
            end
            S_IDLE:  s_axis_tready = 1'b1;
            S_HEAD:  pool_rd_en = 1'b1;
            S_CHECK: pool_rd_en = 1'b1;
            S_LINK:  blk_rd_en = 1'b1;
            S_UPDATE: begin
                if (r_op == OP_ALLOC && w_blk_free) begin
                    blk_wr_en    = 1'b1;
                    blk_wr_data  = {1'b0, w_blk_link};
                    pool_wr_en   = 1'b1;
                    pool_wr_data = {w_blk_link, r_total - COUNT_W'(1)};
                end else if (r_op == OP_FREE && !w_blk_free) begin
                    blk_wr_en    = 1'b1;
                    blk_wr_data  = {1'b1, r_head};
                    pool_wr_en   = 1'b1;
                    pool_wr_data = {LINK_W'(r_idx), r_total + COUNT_W'(1)};
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_base      <= '0;
            r_init_slot <= '0;
            r_init_pool <= '0;
            r_init_j    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (r_state == S_INIT) begin
                r_init_slot <= r_init_slot + SLOT_W'(1);
                if (w_init_next == BLK_COUNT[r_init_pool]) begin
                    r_init_j    <= '0;
                    r_init_pool <= r_init_pool + POOL_W'(1);
                end else begin
                    r_init_j <= w_init_next;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and result assembly
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op   <= t_op'(s_axis_tuser);
                    r_size <= s_axis_tdata[SIZE_W-1:0];
                    r_addr <= ADDR_W'(s_axis_tdata[SIZE_W +: OUT_ADDR_W]);
                end
            end
            S_LOCATE: begin
                r_pool       <= w_loc.pool;
                r_diff       <= w_loc.diff;
                r_start      <= w_start;
                r_res_status <= w_loc.status;
                r_res_addr   <= '0;
                r_res_pool   <= w_loc.pool;
                r_res_idx    <= '0;
            end
            S_DIVIDE: begin
                r_idx    <= w_idx.quot;
                r_scaled <= w_idx.scaled;
                r_low_nz <= w_idx.low_nz;
            end
            S_CHECK: begin
                if (w_misaligned) begin
                    r_res_status <= STAT_MISALIGNED;
                    r_res_idx    <= r_idx;
                end
            end
            S_LINK: begin
                r_head  <= w_pool_head;
                r_total <= w_pool_total;
                r_slot  <= w_link_slot;
                r_boff  <= w_boff;
                if (r_op == OP_ALLOC) begin
                    r_idx <= w_pool_head[INDEX_W-1:0];
                    if (w_alloc_empty) begin
                        r_res_status <= STAT_NO_MEMORY;
                    end
                end
            end
            S_UPDATE: begin
                if (r_op == OP_ALLOC) begin
                    if (w_blk_free) begin
                        r_res_status <= STAT_OK;
                        r_res_addr   <= OUT_ADDR_W'(w_alloc_addr);
                        r_res_idx    <= r_idx;
                    end else begin
                        r_res_status <= STAT_NO_MEMORY;
                    end
                end else begin
                    r_res_status <= w_blk_free ? STAT_DOUBLE_FREE : STAT_OK;
                    r_res_idx    <= r_idx;
                end
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_data <= {1'b0, r_res_idx, r_res_pool, r_res_addr, r_res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOCATE))
        else $error("request transfer did not start the locate step");

    a_paired_writes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (blk_wr_en && r_state != S_INIT) |-> pool_wr_en)
        else $error("block store written without the pool head");

    a_alloc_head_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_op == OP_ALLOC) |-> w_blk_free)
        else $error("free list head points at a block in use");

    a_free_total_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_op == OP_FREE && !w_blk_free)
            |-> (r_total < BLK_COUNT[r_pool]))
        else $error("free count would exceed the pool size");

    a_failed_no_address: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[STATUS_W-1:0] != STAT_OK)
            |-> (r_out_data[STATUS_W +: OUT_ADDR_W] == '0))
        else $error("failed request carries a block address");

endmodule

`default_nettype wire
